>>> rtl/pqa_pkg.sv
// shared types and constants for the positive quantile autoscale block
// no dependencies
package pqa_pkg;
  localparam int MaxCells = 4096;
  localparam int AddrW = $clog2(MaxCells);
  localparam int CntW = AddrW + 1;
  localparam int QuantShift = 3;
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_OVFL = 2'd2;

  typedef struct packed {
    logic load;        // store the accepted item
    logic clear;       // restart frame state
    logic pass_start;  // set up a new bit pass
    logic pass_step;   // look at one stored value
    logic pass_end;    // decide the bit
    logic sel_init;    // start a selection
  } pqa_cmd_t;

  typedef struct packed {
    logic       empty;     // no positives stored
    logic       scan_done; // current pass has read every value
    logic       last_bit;  // deciding bit 0
  } pqa_stat_t;
endpackage

>>> rtl/positive_quantile_autoscale_core.sv
// positive quantile autoscale top level: controller plus datapath
// items load one per cycle while in_tready is high; after the last item, 31 bit passes
// over the stored positives select the low bound (no pass if none are stored)
// the pass loop over the value store memory (one read a cycle) bounds the frame rate;
// the next frame is taken only after the result item is accepted
// reset rst_n synchronous active low clears count, maximum and control state
module positive_quantile_autoscale_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // cell_value
  input  logic        in_tlast,   // last_cell
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // low_bound, high_bound, status, zero fill
);
  import pqa_pkg::*;

  pqa_cmd_t cmd;
  pqa_stat_t stat;
  logic signed [31:0] low_bound, high_bound;
  logic [1:0] status;

  pqa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_tvalid && in_tready), .in_last(in_tlast),
    .out_fire(out_tvalid && out_tready), .stat(stat), .cmd(cmd),
    .in_ready(in_tready), .out_valid(out_tvalid)
  );

  pqa_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cell_value(in_tdata), .cmd(cmd), .stat(stat),
    .low_bound(low_bound), .high_bound(high_bound), .status(status)
  );

  assign out_tdata = {6'd0, status, high_bound, low_bound};
endmodule

>>> rtl/pqa_datapath.sv
// datapath: value store, count, maximum and radix selection pass logic
// depends on pqa_pkg
module pqa_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic signed [31:0]    cell_value,
  input  pqa_pkg::pqa_cmd_t     cmd,
  output pqa_pkg::pqa_stat_t    stat,
  output logic signed [31:0]    low_bound,
  output logic signed [31:0]    high_bound,
  output logic [1:0]            status
);
  import pqa_pkg::*;

  logic [31:0]       mem [MaxCells];
  logic [CntW-1:0]   count_r;
  logic signed [31:0] max_r;
  logic              ovfl_r;
  logic [CntW-1:0]   rd_idx_r;
  logic              rd_vld_r;
  logic [31:0]       rd_data_r;
  logic [31:0]       prefix_r;
  logic [CntW-1:0]   k_r;
  logic [CntW-1:0]   zeros_r;
  logic [4:0]        bit_r;
  logic [31:0]       hi_mask;
  logic              match;
  logic              store_ok;

  assign store_ok = cmd.load && (cell_value > 0) && !count_r[CntW-1];
  assign hi_mask = ~((32'd2 << bit_r) - 32'd1);
  assign match = rd_vld_r && ((rd_data_r & hi_mask) == (prefix_r & hi_mask))
                 && !rd_data_r[bit_r];

  always_ff @(posedge clk) begin
    if (store_ok) begin
      mem[count_r[AddrW-1:0]] <= cell_value;
    end
    rd_data_r <= mem[rd_idx_r[AddrW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      count_r <= '0;
      max_r <= 32'sh8000_0000;
      ovfl_r <= 1'b0;
    end else if (cmd.load) begin
      if (cell_value > max_r) max_r <= cell_value;
      if (store_ok) count_r <= count_r + 1'b1;
      else if (cell_value > 0) ovfl_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      rd_vld_r <= 1'b0;
      bit_r <= 5'd30;
    end else begin
      if (cmd.sel_init) begin
        prefix_r <= '0;
        // the last item may still be going into the store this cycle
        k_r <= (count_r + {{(CntW-1){1'b0}}, store_ok}) >> QuantShift;
        bit_r <= 5'd30;
      end
      if (cmd.pass_start) begin
        rd_idx_r <= '0;
        rd_vld_r <= 1'b0;
        zeros_r <= '0;
      end
      if (cmd.pass_step) begin
        rd_vld_r <= (rd_idx_r < count_r);
        if (rd_idx_r < count_r) rd_idx_r <= rd_idx_r + 1'b1;
        if (match) zeros_r <= zeros_r + 1'b1;
      end
      if (cmd.pass_end) begin
        if (k_r >= zeros_r) begin
          k_r <= k_r - zeros_r;
          prefix_r[bit_r] <= 1'b1;
        end
        bit_r <= bit_r - 5'd1;
      end
    end
  end

  // pass finished once every index is issued and the last read is counted
  assign stat.scan_done = (rd_idx_r == count_r) && !rd_vld_r;
  assign stat.empty = (count_r == '0);
  assign stat.last_bit = (bit_r == 5'd0);
  assign low_bound = stat.empty ? 32'sd0 : prefix_r;
  assign high_bound = max_r;
  assign status = stat.empty ? STATUS_EMPTY : (ovfl_r ? STATUS_OVFL : STATUS_OK);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(MaxCells)) else $error("count beyond store");
  a_prefix_sign: assert property (@(posedge clk) disable iff (!rst_n)
    prefix_r[31] == 1'b0 || $past(cmd.sel_init) == 1'b0) else $error("prefix sign");
  a_ovfl_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovfl_r |-> count_r == CntW'(MaxCells)) else $error("overflow before full");
endmodule

>>> rtl/pqa_ctrl.sv
// controller state machine: load, selection passes, result hold
// depends on pqa_pkg
module pqa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  input  logic               in_last,
  input  logic               out_fire,
  input  pqa_pkg::pqa_stat_t stat,
  output pqa_pkg::pqa_cmd_t  cmd,
  output logic               in_ready,
  output logic               out_valid
);
  import pqa_pkg::*;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
        if (in_fire && in_last) begin
          cmd.sel_init = 1'b1;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.pass_start = 1'b1;
        state_nxt = stat.empty ? S_OUT : S_SCAN;
      end
      S_SCAN: begin
        cmd.pass_step = 1'b1;
        if (stat.scan_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.pass_end = 1'b1;
        state_nxt = stat.last_bit ? S_OUT : S_START;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_fire) begin
          cmd.clear = 1'b1;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_LOAD;
    else state_r <= state_nxt;
  end

  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input open during result");
  a_out_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_fire) |=> out_valid) else $error("result dropped");
  a_sel_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last) |=> state_r == S_START) else $error("no selection");
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// testbench for positive_quantile_autoscale_core: frames of q16.16 cells in, bounds out
// depends on pqa_pkg and the core rtl
module tb;
  import pqa_pkg::*;

  typedef struct packed {
    logic [31:0] low_bound;
    logic [31:0] high_bound;
    logic [1:0]  status;
  } bounds_t;

  class bounds_scoreboard;
    logic [31:0] store[$];
    logic signed [31:0] frame_max;
    logic dropped;
    bounds_t pending[$];
    int errors;
    int frames;

    function new();
      errors = 0;
      frames = 0;
      clear();
    endfunction

    function void clear();
      store.delete();
      frame_max = 32'sh80000000;
      dropped = 1'b0;
    endfunction

    // k-th smallest by sorting a copy
    function logic [31:0] kth_smallest(int k);
      logic [31:0] tmp[$];
      tmp = store;
      tmp.sort();
      return tmp[k];
    endfunction

    function void note_cell(logic signed [31:0] v, logic last);
      bounds_t r;
      if (v > frame_max) frame_max = v;
      if (v > 0) begin
        if (store.size() < MaxCells) store.push_back(v);
        else dropped = 1'b1;
      end
      if (last) begin
        if (store.size() == 0) begin
          r.low_bound = '0;
          r.status = STATUS_EMPTY;
        end else begin
          r.low_bound = kth_smallest(store.size() >> QuantShift);
          r.status = dropped ? STATUS_OVFL : STATUS_OK;
        end
        r.high_bound = frame_max;
        pending.push_back(r);
        clear();
      end
    endfunction

    function void check_bounds(logic [71:0] d);
      bounds_t got, exp;
      got.low_bound = d[31:0];
      got.high_bound = d[63:32];
      got.status = d[65:64];
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        errors++;
        return;
      end
      exp = pending.pop_front();
      frames++;
      if (got.low_bound !== exp.low_bound)
        $display("%0t: low_bound expected %h actual %h", $time, exp.low_bound, got.low_bound);
      if (got.high_bound !== exp.high_bound)
        $display("%0t: high_bound expected %h actual %h", $time, exp.high_bound,
                 got.high_bound);
      if (got.status !== exp.status)
        $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
      if (got.low_bound !== exp.low_bound || got.high_bound !== exp.high_bound ||
          got.status !== exp.status || d[71:66] !== 6'd0)
        errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [71:0] out_tdata;

  bounds_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off = 0;
  bit stim_done = 0;
  int cycles = 0;
  int cells_sent = 0;

  localparam int CycleLimit = 4000000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  positive_quantile_autoscale_core DUT (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("positive_quantile_autoscale_core: mismatch");
      $finish;
    end
  end

  // receiver: random stall, plus long hold-off on request
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_bounds(out_tdata);
    out_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // valid stays up between back to back items and drops only while idling
  task automatic send_cell(logic [31:0] v, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_cell(v, last);
    cells_sent++;
  endtask

  function automatic logic [31:0] rand_cell();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(8);
      2: return 32'h80000000 | $urandom_range(3);
      3: return 32'h7ffffff0 | $urandom_range(15);
      4: return $urandom_range(32'h00100000);
      default: return 32'(-$signed({1'b0, $urandom_range(32'h00100000)}));
    endcase
  endfunction

  task automatic send_frame(int n);
    for (int i = 0; i < n; i++) send_cell(rand_cell(), i == n - 1);
  endtask

  initial begin
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, empty frame, duplicates, single cell
    send_cell(32'h80000000, 1);
    send_cell(32'h00000000, 1);
    send_cell(32'h7fffffff, 1);
    send_cell(32'h00000001, 1);
    for (int i = 0; i < 9; i++) send_cell(32'h00010000, i == 8);
    send_cell(32'hffffffff, 0);
    send_cell(32'h7fffffff, 0);
    send_cell(32'h00000001, 0);
    send_cell(32'h55555555, 0);
    send_cell(32'h2aaaaaaa, 1);
    // overflow frame: one negative cell and one more positive than the store holds
    for (int i = 0; i <= MaxCells + 1; i++)
      send_cell((i == 5) ? 32'hfffe0000 : (32'h1 + $urandom_range(32'h3fff)),
                i == MaxCells + 1);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 88 : 0;
      recv_idle_pct = (ph == 0) ? 88 : (ph == 1) ? 12 : 0;
      for (int f = 0; f < 45; f++) begin
        if (ph == 2 && f == 5) begin
          hold_off = 1;
          fork
            begin repeat (3000) @(posedge clk); hold_off = 0; end
          join_none
        end
        n = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
        send_frame(n);
      end
    end
    in_tvalid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d cells, checked %0d frames including empty and overflow cases",
             cells_sent, sb.frames);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("positive_quantile_autoscale_core: match");
    else
      $display("positive_quantile_autoscale_core: mismatch");
    $finish;
  end
endmodule

>>> positive_quantile_autoscale_core.f
rtl/pqa_pkg.sv
rtl/pqa_datapath.sv
rtl/pqa_ctrl.sv
rtl/positive_quantile_autoscale_core.sv
tb/sv/tb.sv
